### hdl/ubs_pkg.sv
// Shared types and constants for the upper-triangular back substitution solver.
package ubs_pkg;

    localparam int unsigned MAX_SIZE_DEF = 16;
    localparam int unsigned IDX_W        = 4;
    localparam int unsigned VAL_W        = 32;
    localparam int unsigned ACC_W        = 64;
    localparam int unsigned SIZE_W       = 5;
    localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

    typedef enum logic [1:0] {
        CMD_WR_MAT = 2'd0,
        CMD_WR_VEC = 2'd1,
        CMD_SOLVE  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] solution;
        logic                    last;
        logic                    zero_pivot;
    } t_out_item;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] num;
        logic signed [VAL_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [VAL_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROWB,
        S_ROWD,
        S_MRD,
        S_MUL,
        S_ACC,
        S_DIVS,
        S_DIVW,
        S_OUT
    } t_state;

endpackage

### hdl/ubs_cell.sv
// One cell of the solved-element chain: holds one x value, shifts from its neighbor.
module ubs_cell (
    input  logic                               i_clk,
    input  logic                               i_shift,
    input  logic signed [ubs_pkg::VAL_W-1:0]   i_prev,
    output logic signed [ubs_pkg::VAL_W-1:0]   o_val
);

    logic signed [ubs_pkg::VAL_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_prev;
        end
    end

    assign o_val = r_val;

endmodule

### hdl/ubs_divider.sv
// Radix-2 restoring divider: Q32.32 by Q16.16, truncated, saturated to 32 bits.
module ubs_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ubs_pkg::t_div_req i_req,
    output ubs_pkg::t_div_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [5:0]                      r_cnt;
    logic [32:0]                     r_rem;
    logic [31:0]                     r_low;
    logic [31:0]                     r_q;
    logic [31:0]                     r_ud;
    logic                            r_neg;
    logic signed [ubs_pkg::VAL_W-1:0] r_quot;

    logic [63:0] w_un;
    logic [31:0] w_ud;
    logic [32:0] w_rem2;
    logic        w_ge;
    logic [31:0] w_qn;

    assign w_un   = i_req.num[63] ? (64'd0 - 64'(i_req.num)) : 64'(i_req.num);
    assign w_ud   = i_req.den[31] ? (32'd0 - 32'(i_req.den)) : 32'(i_req.den);
    assign w_rem2 = {r_rem[31:0], r_low[31]};
    assign w_ge   = w_rem2 >= {1'b0, r_ud};
    assign w_qn   = {r_q[30:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_neg <= i_req.num[63] ^ i_req.den[31];
                r_ud  <= w_ud;
                if (w_un[63:32] >= w_ud) begin
                    // quotient needs more than 32 bits: saturate at once
                    r_quot <= (i_req.num[63] ^ i_req.den[31]) ? 32'sh8000_0000
                                                              : 32'sh7FFF_FFFF;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= {1'b0, w_un[63:32]};
                    r_low  <= w_un[31:0];
                    r_q    <= '0;
                    r_cnt  <= 6'd32;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_rem2 - {1'b0, r_ud}) : w_rem2;
                r_low <= {r_low[30:0], 1'b0};
                r_q   <= w_qn;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (r_neg) begin
                        r_quot <= w_qn[31] ? 32'sh8000_0000 : $signed(32'd0 - w_qn);
                    end else begin
                        r_quot <= w_qn[31] ? 32'sh7FFF_FFFF : $signed(w_qn);
                    end
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

### hdl/upper_triangular_back_substitution.sv
// Top level: element stores, solve sequencer, x cell chain, MAC and divider.
//
// Input channel (i_in_valid / o_in_ready, i_in_data): each transaction writes
// one matrix element (cmd 0), one right-hand-side element (cmd 1), or starts
// a solve (cmd 2). Writes beyond the store are dropped.
// Output channel (o_out_valid / i_out_ready, o_out_data): a solve returns one
// transaction per row from n-1 down to 0, row 0 flagged last.
// Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data): system size,
// written by the user only while no solve is running; not enforced. Always ready.
// Steps per solve row i of n: states S_ROWB and S_ROWD read the stores and pivot,
// then each of the n-1-i multiply-accumulates runs S_MRD, S_MUL and S_ACC
// (memory read, 32x32 multiply, saturating 64-bit subtract), then the bit-serial
// divider runs (cut short when the quotient overflows, not started on a zero
// pivot); S_OUT hands the result to the output register. The divider dominates.
// Input is not taken while a solve runs. When the receiver stalls, the
// sequencer holds the next result until the output register frees.
// Reset clears control state and sets the size to 16; the stores hold
// unknown data until written and need no clearing pass.
module upper_triangular_back_substitution #(
    parameter int unsigned MAX_SIZE = ubs_pkg::MAX_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ubs_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ubs_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ubs_pkg::SIZE_W-1:0]          i_cfg_data
);

    localparam int unsigned ROW_LIMIT = (MAX_SIZE < 16) ? MAX_SIZE : 16;
    localparam int unsigned AW        = $clog2(MAX_SIZE * MAX_SIZE);
    localparam int unsigned VW        = $clog2(MAX_SIZE);
    localparam int unsigned CW        = $clog2(ROW_LIMIT);
    localparam logic [ubs_pkg::SIZE_W-1:0] LIM = ubs_pkg::SIZE_W'(ROW_LIMIT);

    ubs_pkg::t_state r_state, n_state;

    logic [ubs_pkg::SIZE_W-1:0]          r_size;
    logic [ubs_pkg::SIZE_W-1:0]          r_n, n_n;
    logic [ubs_pkg::IDX_W-1:0]           r_i, n_i;
    logic [CW-1:0]                       r_m, n_m;
    logic signed [ubs_pkg::ACC_W-1:0]    r_acc, n_acc;
    logic signed [ubs_pkg::ACC_W-1:0]    r_prod;
    logic signed [ubs_pkg::VAL_W-1:0]    r_diag, n_diag;
    logic signed [ubs_pkg::VAL_W-1:0]    r_x, n_x;
    logic                                r_zp, n_zp;
    logic                                r_out_valid;
    ubs_pkg::t_out_item                  r_out;

    logic signed [ubs_pkg::VAL_W-1:0]    r_mat [MAX_SIZE*MAX_SIZE];
    logic signed [ubs_pkg::VAL_W-1:0]    r_vec [MAX_SIZE];
    logic signed [ubs_pkg::VAL_W-1:0]    r_mrd;
    logic signed [ubs_pkg::VAL_W-1:0]    r_vrd;

    logic [AW-1:0]                       w_maddr;
    logic [AW-1:0]                       w_waddr;
    logic [ubs_pkg::IDX_W:0]             w_col;
    logic                                w_acc_in;
    logic                                w_wr_mat;
    logic                                w_wr_vec;
    logic                                w_out_load;
    logic                                w_div_start;
    logic                                w_in_ready;
    logic [ubs_pkg::SIZE_W-1:0]          w_n_clip;
    logic [5:0]                          w_next1;
    logic [5:0]                          w_next2;
    logic signed [ubs_pkg::ACC_W:0]      w_diff;
    logic signed [ubs_pkg::ACC_W-1:0]    w_sat;
    logic signed [ubs_pkg::VAL_W-1:0]    w_cell [ROW_LIMIT];
    ubs_pkg::t_div_req                   w_dreq;
    ubs_pkg::t_div_rsp                   w_drsp;

    assign w_acc_in = i_in_valid && w_in_ready;
    assign w_wr_mat = w_acc_in && (i_in_data.cmd == ubs_pkg::CMD_WR_MAT)
                      && ({1'b0, i_in_data.row} < LIM) && ({1'b0, i_in_data.col} < LIM);
    assign w_wr_vec = w_acc_in && (i_in_data.cmd == ubs_pkg::CMD_WR_VEC)
                      && ({1'b0, i_in_data.row} < LIM);
    assign w_waddr  = AW'(i_in_data.row) * AW'(MAX_SIZE) + AW'(i_in_data.col);

    assign w_n_clip = (r_size == '0) ? ubs_pkg::SIZE_W'(1) :
                      ((r_size > LIM) ? LIM : r_size);
    assign w_next1  = 6'(r_i) + 6'd1 + 6'(r_m);
    assign w_next2  = 6'(r_i) + 6'd2 + 6'(r_m);

    assign w_diff = {r_acc[ubs_pkg::ACC_W-1], r_acc} - {r_prod[ubs_pkg::ACC_W-1], r_prod};
    assign w_sat  = (w_diff[ubs_pkg::ACC_W] != w_diff[ubs_pkg::ACC_W-1]) ?
                    (w_diff[ubs_pkg::ACC_W] ? {1'b1, {(ubs_pkg::ACC_W-1){1'b0}}}
                                            : {1'b0, {(ubs_pkg::ACC_W-1){1'b1}}}) :
                    w_diff[ubs_pkg::ACC_W-1:0];

    // stores
    always_ff @(posedge i_clk) begin
        if (w_wr_mat) begin
            r_mat[w_waddr] <= i_in_data.value;
        end
        if (w_wr_vec) begin
            r_vec[VW'(i_in_data.row)] <= i_in_data.value;
        end
        r_mrd <= r_mat[w_maddr];
        r_vrd <= r_vec[VW'(r_i)];
    end

    // x chain: new x enters cell 0, older values move one cell up
    genvar g;
    generate
        for (g = 0; g < ROW_LIMIT; g++) begin : g_cell
            if (g == 0) begin : g_head
                ubs_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(w_out_load),
                    .i_prev (r_x),
                    .o_val  (w_cell[g])
                );
            end else begin : g_body
                ubs_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(w_out_load),
                    .i_prev (w_cell[g-1]),
                    .o_val  (w_cell[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_prod <= ubs_pkg::ACC_W'(r_mrd) * ubs_pkg::ACC_W'(w_cell[r_m]);
    end

    assign w_dreq.start = w_div_start;
    assign w_dreq.num   = r_acc;
    assign w_dreq.den   = r_diag;

    ubs_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_m     = r_m;
        n_acc   = r_acc;
        n_diag  = r_diag;
        n_x     = r_x;
        n_zp    = r_zp;
        case (r_state)
            ubs_pkg::S_IDLE: begin
                if (w_acc_in && i_in_data.cmd == ubs_pkg::CMD_SOLVE) begin
                    n_n     = w_n_clip;
                    n_i     = ubs_pkg::IDX_W'(w_n_clip - ubs_pkg::SIZE_W'(1));
                    n_state = ubs_pkg::S_ROWB;
                end
            end
            ubs_pkg::S_ROWB: n_state = ubs_pkg::S_ROWD;
            ubs_pkg::S_ROWD: begin
                n_acc  = {{16{r_vrd[31]}}, r_vrd, 16'd0};
                n_diag = r_mrd;
                n_m    = '0;
                n_state = (6'(r_i) + 6'd1 < 6'(r_n)) ? ubs_pkg::S_MRD : ubs_pkg::S_DIVS;
            end
            ubs_pkg::S_MRD: n_state = ubs_pkg::S_MUL;
            ubs_pkg::S_MUL: n_state = ubs_pkg::S_ACC;
            ubs_pkg::S_ACC: begin
                n_acc = w_sat;
                if (w_next2 < 6'(r_n)) begin
                    n_m     = r_m + CW'(1);
                    n_state = ubs_pkg::S_MRD;
                end else begin
                    n_state = ubs_pkg::S_DIVS;
                end
            end
            ubs_pkg::S_DIVS: begin
                if (r_diag == '0) begin
                    n_x     = '0;
                    n_zp    = 1'b1;
                    n_state = ubs_pkg::S_OUT;
                end else begin
                    n_zp    = 1'b0;
                    n_state = ubs_pkg::S_DIVW;
                end
            end
            ubs_pkg::S_DIVW: begin
                if (w_drsp.done) begin
                    n_x     = w_drsp.quot;
                    n_state = ubs_pkg::S_OUT;
                end
            end
            ubs_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_i == '0) begin
                        n_state = ubs_pkg::S_IDLE;
                    end else begin
                        n_i     = r_i - ubs_pkg::IDX_W'(1);
                        n_state = ubs_pkg::S_ROWB;
                    end
                end
            end
            default: n_state = ubs_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        w_col       = {1'b0, r_i};
        w_maddr     = '0;
        case (r_state)
            ubs_pkg::S_IDLE: w_in_ready = 1'b1;
            ubs_pkg::S_ROWB: w_maddr = AW'(r_i) * AW'(MAX_SIZE) + AW'(r_i);
            ubs_pkg::S_MRD: begin
                w_col   = w_next1[ubs_pkg::IDX_W:0];
                w_maddr = AW'(r_i) * AW'(MAX_SIZE) + AW'(w_col);
            end
            ubs_pkg::S_DIVS: w_div_start = (r_diag != '0);
            ubs_pkg::S_OUT:  w_out_load  = !r_out_valid || i_out_ready;
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ubs_pkg::S_IDLE;
            r_size      <= ubs_pkg::SIZE_RST;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_m         <= '0;
            r_n         <= ubs_pkg::SIZE_RST;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_m     <= n_m;
            r_n     <= n_n;
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_diag <= n_diag;
        r_x    <= n_x;
        r_zp   <= n_zp;
        if (w_out_load) begin
            r_out.index      <= r_i;
            r_out.solution   <= r_x;
            r_out.last       <= (r_i == '0);
            r_out.zero_pivot <= r_zp;
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_last_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last == (o_out_data.index == '0)))
        else $error("last flag on a row other than 0");

    a_zp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.zero_pivot) |-> (o_out_data.solution == '0))
        else $error("zero pivot with nonzero solution");

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_drsp.busy)
        else $error("input taken while divider busy");

    a_mac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ubs_pkg::S_MRD) |-> (w_next1 < 6'(r_n)))
        else $error("MAC column beyond system size");

endmodule

### tb/sv/upper_triangular_back_substitution_test.sv
// Regression bench for the upper-triangular back substitution solver.
`timescale 1ns / 100ps

module upper_triangular_back_substitution_test;

    localparam int LIMIT_CYCLES = 2_000_000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    ubs_pkg::t_in_item          i_in_data = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    ubs_pkg::t_out_item         o_out_data;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [ubs_pkg::SIZE_W-1:0] i_cfg_data = '0;

    upper_triangular_back_substitution dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // solver state mirror
    logic signed [31:0]         mat_copy [16][16];
    logic signed [31:0]         rhs_copy [16];
    logic [ubs_pkg::SIZE_W-1:0] size_reg = ubs_pkg::SIZE_RST;
    ubs_pkg::t_out_item         solution_queue [$];
    int                         errors = 0;
    longint                     cycle_count = 0;
    bit                         hold_off = 1'b0;
    bit                         stall_enable = 1'b1;

    function automatic logic signed [31:0] quotient_sat(logic signed [63:0] num,
                                                         logic signed [31:0] den);
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] q;
        bit neg;
        neg = (num < 0) != (den < 0);
        un = (num < 0) ? 64'd0 - num : num;
        ud = (den < 0) ? 64'd0 - {{32{den[31]}}, den} : {32'd0, den};
        q = un / ud;
        if (neg) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
        return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
    endfunction

    task automatic predict_solve();
        logic signed [31:0]  x [16];
        logic signed [63:0]  acc;
        logic signed [63:0]  prod;
        logic signed [64:0]  wide;
        logic signed [31:0]  diag;
        ubs_pkg::t_out_item  r;
        int n;
        n = size_reg;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        for (int i = n - 1; i >= 0; i--) begin
            acc = {{16{rhs_copy[i][31]}}, rhs_copy[i], 16'd0};
            for (int j = i + 1; j < n; j++) begin
                prod = 64'(mat_copy[i][j]) * 64'(x[j]);
                wide = 65'(acc) - 65'(prod);
                if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) acc = 64'sh7FFF_FFFF_FFFF_FFFF;
                else if (wide < -65'sh0_8000_0000_0000_0000) acc = 64'sh8000_0000_0000_0000;
                else acc = wide[63:0];
            end
            diag = mat_copy[i][i];
            x[i] = (diag == 0) ? 32'sd0 : quotient_sat(acc, diag);
            r.index = i[3:0];
            r.solution = x[i];
            r.last = (i == 0);
            r.zero_pivot = (diag == 0);
            solution_queue.push_back(r);
        end
    endtask

    task automatic send_item(ubs_pkg::t_cmd c, int r, int col, logic [31:0] v);
        int gap;
        i_in_data <= '{cmd: c, row: r[3:0], col: col[3:0], value: v};
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        case (c)
            ubs_pkg::CMD_WR_MAT: mat_copy[r][col] = v;
            ubs_pkg::CMD_WR_VEC: rhs_copy[r] = v;
            ubs_pkg::CMD_SOLVE:  predict_solve();
            default: ;
        endcase
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (solution_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_size(int n);
        drain();
        i_cfg_data <= n[ubs_pkg::SIZE_W-1:0];
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        size_reg = n[ubs_pkg::SIZE_W-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            default: return $urandom;
        endcase
    endfunction

    // full upper triangle and rhs of size n, then a solve
    task automatic load_and_solve(int n, bit small_vals);
        logic [31:0] v;
        for (int i = 0; i < n; i++) begin
            for (int j = i; j < n; j++) begin
                v = small_vals ? 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16))
                               : rand_value();
                if (i == j && small_vals && $urandom_range(0, 9) != 0 && v == 0)
                    v = 32'h0001_0000;
                send_item(ubs_pkg::CMD_WR_MAT, i, j, v);
            end
            send_item(ubs_pkg::CMD_WR_VEC, i, 0, small_vals ? 32'($signed($urandom)) >>> 8
                                                            : rand_value());
        end
        send_item(ubs_pkg::CMD_SOLVE, 0, 0, 32'd0);
    endtask

    task automatic test_directed();
        write_size(2);
        send_item(ubs_pkg::CMD_WR_MAT, 0, 0, 32'h0002_0000);
        send_item(ubs_pkg::CMD_WR_MAT, 0, 1, 32'h8000_0000);
        send_item(ubs_pkg::CMD_WR_MAT, 1, 0, 32'h7FFF_FFFF);   // lower triangle, unused
        send_item(ubs_pkg::CMD_WR_MAT, 1, 1, 32'h0000_0000);   // zero pivot
        send_item(ubs_pkg::CMD_WR_VEC, 0, 15, 32'h7FFF_FFFF);
        send_item(ubs_pkg::CMD_WR_VEC, 1, 0, 32'h8000_0000);
        send_item(ubs_pkg::CMD_SOLVE, 0, 0, 32'd0);
        send_item(ubs_pkg::CMD_SOLVE, 15, 15, 32'hFFFF_FFFF);  // repeated solve
        send_item(ubs_pkg::CMD_NONE, 3, 3, 32'h1234_5678);     // ignored command
        send_item(ubs_pkg::CMD_WR_MAT, 1, 1, 32'h0000_0001);   // tiny pivot saturates
        send_item(ubs_pkg::CMD_WR_VEC, 1, 0, 32'h7FFF_FFFF);
        send_item(ubs_pkg::CMD_SOLVE, 0, 0, 32'd0);
        write_size(1);
        send_item(ubs_pkg::CMD_WR_MAT, 0, 0, 32'hFFFF_0000);
        send_item(ubs_pkg::CMD_SOLVE, 0, 0, 32'd0);
        write_size(0);                                         // acts as 1
        send_item(ubs_pkg::CMD_SOLVE, 0, 0, 32'd0);
    endtask

    task automatic test_full_size();
        write_size(16);
        load_and_solve(16, 1'b1);
        write_size(31);                                        // clamps to 16
        send_item(ubs_pkg::CMD_SOLVE, 0, 0, 32'd0);
    endtask

    // full-size system still loaded: receiver holds off while solves queue up
    task automatic test_backpressure();
        hold_off = 1'b1;
        send_item(ubs_pkg::CMD_SOLVE, 0, 0, 32'd0);
        send_item(ubs_pkg::CMD_SOLVE, 0, 0, 32'd0);
        send_item(ubs_pkg::CMD_WR_VEC, 2, 0, 32'h0003_0000);
        send_item(ubs_pkg::CMD_SOLVE, 0, 0, 32'd0);
        drain();
    endtask

    task automatic test_random();
        int n;
        int k;
        for (int s = 0; s < 2; s++) begin
            n = $urandom_range(1, 3);
            write_size(n);
            load_and_solve(n, $urandom_range(0, 2) != 0);
            for (k = 0; k < 3; k++) begin
                case ($urandom_range(0, 3))
                    0: send_item(ubs_pkg::CMD_WR_MAT, $urandom_range(0, n - 1),
                                 $urandom_range(0, n - 1), rand_value());
                    1: send_item(ubs_pkg::CMD_WR_VEC, $urandom_range(0, n - 1), $urandom,
                                 rand_value());
                    2: send_item(ubs_pkg::CMD_NONE, $urandom, $urandom, $urandom);
                    default: send_item(ubs_pkg::CMD_SOLVE, $urandom, $urandom, $urandom);
                endcase
            end
            send_item(ubs_pkg::CMD_SOLVE, 0, 0, 32'd0);
        end
    endtask

    // receiver ready, with random stalls and a long commanded hold-off
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_out_ready <= 1'b0;
            repeat (400) @(posedge i_clk);
            hold_off = 1'b0;
        end else if (stall_enable) begin
            i_out_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // result check
    always @(posedge i_clk) begin
        ubs_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (solution_queue.size() == 0) begin
                $display("%0t: unexpected transaction %p", $time, o_out_data);
                errors++;
            end else begin
                want = solution_queue.pop_front();
                if (o_out_data.index !== want.index) begin
                    $display("%0t: index exp %0d got %0d", $time, want.index, o_out_data.index);
                    errors++;
                end
                if (o_out_data.solution !== want.solution) begin
                    $display("%0t: solution[%0d] exp %h got %h", $time, want.index,
                             want.solution, o_out_data.solution);
                    errors++;
                end
                if (o_out_data.last !== want.last) begin
                    $display("%0t: last exp %b got %b", $time, want.last, o_out_data.last);
                    errors++;
                end
                if (o_out_data.zero_pivot !== want.zero_pivot) begin
                    $display("%0t: zero_pivot exp %b got %b", $time, want.zero_pivot,
                             o_out_data.zero_pivot);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("upper_triangular_back_substitution regression: fail");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 16; i++) begin
            rhs_copy[i] = 0;
            for (int j = 0; j < 16; j++) mat_copy[i][j] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_size();
        test_backpressure();
        test_random();
        stall_enable = 1'b0;
        drain();
        if (errors == 0 && solution_queue.size() == 0)
            $display("upper_triangular_back_substitution regression: pass");
        else
            $display("upper_triangular_back_substitution regression: fail");
        $finish;
    end

endmodule

### filelist.f
hdl/ubs_pkg.sv
hdl/ubs_cell.sv
hdl/ubs_divider.sv
hdl/upper_triangular_back_substitution.sv
tb/sv/upper_triangular_back_substitution_test.sv
